@@ rtl/tle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet line editor package
// Byte type, operation codes and the character constants of the editor.
// ----------------------------------------------------------------------------
package tle_pkg;

	typedef logic [7:0] byte_t;

	// operation codes of an input item
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_SESSION = 1'b1;

	// result destinations
	localparam logic DEST_ECHO = 1'b0;
	localparam logic DEST_LINE = 1'b1;

	// characters
	localparam byte_t CH_IAC     = 8'hFF;
	localparam byte_t CH_OPT_MIN = 8'hFB;
	localparam byte_t CH_DEL     = 8'h7F;
	localparam byte_t CH_BS      = 8'h08;
	localparam byte_t CH_SPACE   = 8'h20;
	localparam byte_t CH_CR      = 8'h0D;
	localparam byte_t CH_LF      = 8'h0A;
	localparam byte_t CH_GT      = 8'h3E;

endpackage

@@ rtl/tle_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet line editor channels
// Valid/ready channels for received bytes and for produced bytes.
// ----------------------------------------------------------------------------
interface tle_in_if;
	logic           valid;
	logic           ready;
	logic           operation;
	tle_pkg::byte_t in_byte;

	modport source(output valid, output operation, output in_byte, input ready);
	modport sink(input valid, input operation, input in_byte, output ready);
endinterface

interface tle_out_if;
	logic           valid;
	logic           ready;
	tle_pkg::byte_t out_byte;
	logic           out_dest;
	logic           out_last;

	modport source(output valid, output out_byte, output out_dest, output out_last,
		input ready);
	modport sink(input valid, input out_byte, input out_dest, input out_last,
		output ready);
endinterface

@@ rtl/telnet_line_editor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet line editor
// Strips telnet IAC sequences, edits a line with backspace and echo, and
// passes a finished line to the command dispatcher.
// ----------------------------------------------------------------------------
// Usage:
//   line_in  carries one item per received byte (operation 0) or a session
//            start (operation 1). It is taken only while the editor is idle.
//   line_out carries the produced bytes: out_dest 0 is echo to the client,
//            out_dest 1 is a stored line byte for the dispatcher; out_last
//            marks the final byte of one item's run.
// Timing:
//   An item that produces nothing is handled in the idle state alone. An item
//   that produces bytes is decoded in the idle state, then loads one byte per
//   cycle into the output register while that register is free. Carriage
//   return gives 4 + line length bytes.
// Reset:
//   arst_n clears the IAC flags, the line length and the output register.
//   The line store itself needs no clearing; only written entries are read.
// Backpressure:
//   The output register holds its item while line_out.ready is low, and the
//   editor pauses in its current step until the register frees up.
// ----------------------------------------------------------------------------
module telnet_line_editor #(
	parameter int LINE_BYTES = 32,
	localparam int LW = $clog2(LINE_BYTES)
) (
	input logic      clk,
	input logic      arst_n,
	tle_in_if.sink   line_in,
	tle_out_if.source line_out
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ECHO,
		ST_BS1,
		ST_SP,
		ST_BS2,
		ST_CR,
		ST_LF,
		ST_LINE,
		ST_GT,
		ST_PSP
	} state_t;

	state_t         state_q;
	logic           iac_seen_q;
	logic           skip_option_q;
	logic [LW-1:0]  len_q;
	logic [LW-1:0]  rd_idx_q;
	tle_pkg::byte_t echo_q;

	logic           out_valid_q;
	tle_pkg::byte_t out_byte_q;
	logic           out_dest_q;
	logic           out_last_q;

	logic           accept;
	logic           slot_free;
	logic           emit;
	logic           is_printable;
	logic           has_room;
	logic           wr_en;
	logic           rd_en;
	logic [LW-1:0]  rd_addr;
	tle_pkg::byte_t rd_data;
	logic           line_done;

	// Take a new item only when idle; results drain through the output register.
	assign line_in.ready = (state_q == ST_IDLE);
	assign accept        = line_in.valid && line_in.ready;
	assign slot_free     = !out_valid_q || line_out.ready;
	// Every busy state loads one byte into the output register when it is free.
	assign emit          = slot_free && (state_q != ST_IDLE);

	assign is_printable = (line_in.in_byte >= tle_pkg::CH_SPACE)
		&& (line_in.in_byte != tle_pkg::CH_DEL)
		&& (line_in.in_byte != tle_pkg::CH_IAC);
	assign has_room     = (len_q != LW'(LINE_BYTES - 1));

	// Store a printable byte at the end of the line.
	assign wr_en = accept && (line_in.operation == tle_pkg::OP_BYTE)
		&& !skip_option_q && !iac_seen_q && is_printable && has_room;

	// Drain reads run one entry ahead of the byte being emitted.
	assign line_done = (rd_idx_q == len_q - LW'(1));
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			ST_LF: begin
				rd_en = slot_free && (len_q != '0);
			end
			ST_LINE: begin
				rd_en   = slot_free && !line_done;
				rd_addr = rd_idx_q + LW'(1);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	tle_line_ram #(
		.DEPTH(LINE_BYTES)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(len_q),
		.wr_data(line_in.in_byte),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			iac_seen_q    <= 1'b0;
			skip_option_q <= 1'b0;
			len_q         <= '0;
			rd_idx_q      <= '0;
			echo_q        <= '0;
			out_valid_q   <= 1'b0;
			out_byte_q    <= '0;
			out_dest_q    <= tle_pkg::DEST_ECHO;
			out_last_q    <= 1'b0;
		end else begin
			// Drop the held item once the receiver takes it and nothing replaces it.
			if (line_out.ready && !emit) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (line_in.operation == tle_pkg::OP_SESSION) begin
							iac_seen_q    <= 1'b0;
							skip_option_q <= 1'b0;
							len_q         <= '0;
							state_q       <= ST_GT;
						end else if (skip_option_q) begin
							// option code of a negotiation: discard
							skip_option_q <= 1'b0;
						end else if (iac_seen_q) begin
							iac_seen_q    <= 1'b0;
							skip_option_q <= (line_in.in_byte >= tle_pkg::CH_OPT_MIN);
						end else if (line_in.in_byte == tle_pkg::CH_IAC) begin
							iac_seen_q <= 1'b1;
						end else if (line_in.in_byte == tle_pkg::CH_CR) begin
							state_q <= ST_CR;
						end else if ((line_in.in_byte == tle_pkg::CH_DEL)
							|| (line_in.in_byte == tle_pkg::CH_BS)) begin
							if (len_q != '0) begin
								len_q   <= len_q - LW'(1);
								state_q <= ST_BS1;
							end
						end else if (is_printable) begin
							if (has_room) begin
								len_q   <= len_q + LW'(1);
								echo_q  <= line_in.in_byte;
								state_q <= ST_ECHO;
							end
						end else begin
							// control bytes and LF fall through untouched
						end
					end
				end
				ST_ECHO: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= echo_q;
						out_dest_q  <= tle_pkg::DEST_ECHO;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_BS1: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= tle_pkg::CH_BS;
						out_dest_q  <= tle_pkg::DEST_ECHO;
						out_last_q  <= 1'b0;
						state_q     <= ST_SP;
					end
				end
				ST_SP: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= tle_pkg::CH_SPACE;
						out_dest_q  <= tle_pkg::DEST_ECHO;
						out_last_q  <= 1'b0;
						state_q     <= ST_BS2;
					end
				end
				ST_BS2: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= tle_pkg::CH_BS;
						out_dest_q  <= tle_pkg::DEST_ECHO;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_CR: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= tle_pkg::CH_CR;
						out_dest_q  <= tle_pkg::DEST_ECHO;
						out_last_q  <= 1'b0;
						state_q     <= ST_LF;
					end
				end
				ST_LF: begin
					// The first line entry is read here when there is a line.
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= tle_pkg::CH_LF;
						out_dest_q  <= tle_pkg::DEST_ECHO;
						out_last_q  <= 1'b0;
						rd_idx_q    <= '0;
						state_q     <= (len_q != '0) ? ST_LINE : ST_GT;
					end
				end
				ST_LINE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= rd_data;
						out_dest_q  <= tle_pkg::DEST_LINE;
						out_last_q  <= 1'b0;
						if (line_done) begin
							len_q   <= '0;
							state_q <= ST_GT;
						end else begin
							rd_idx_q <= rd_idx_q + LW'(1);
						end
					end
				end
				ST_GT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= tle_pkg::CH_GT;
						out_dest_q  <= tle_pkg::DEST_ECHO;
						out_last_q  <= 1'b0;
						state_q     <= ST_PSP;
					end
				end
				ST_PSP: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= tle_pkg::CH_SPACE;
						out_dest_q  <= tle_pkg::DEST_ECHO;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign line_out.valid    = out_valid_q;
	assign line_out.out_byte = out_byte_q;
	assign line_out.out_dest = out_dest_q;
	assign line_out.out_last = out_last_q;

endmodule

@@ rtl/tle_line_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line store RAM
// One write port, one read port, read data registered and held between reads.
// ----------------------------------------------------------------------------
module tle_line_ram #(
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  tle_pkg::byte_t wr_data,
	input  logic           rd_en,
	input  logic [AW-1:0]  rd_addr,
	output tle_pkg::byte_t rd_data
);

	tle_pkg::byte_t mem [DEPTH];
	tle_pkg::byte_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
